@@ hdl/gtd_pkg.sv @@
// gtd_pkg: shared constants, types and the arctangent table of the tone detector
// no dependencies
`timescale 1ns / 1ps

package gtd_pkg;

  localparam int SAMPLE_WIDTH = 16;   // sample bits taken into the resonator
  localparam int SMP_W        = 16;   // sample field width on the port
  localparam int ST_W         = 40;   // resonator state width
  localparam int COEF_W       = 16;
  localparam int BLEN_W       = 10;
  localparam int CFG_W        = 16;   // widest register
  localparam int MA_W         = 56;   // multiplicand width of the serial multiplier
  localparam int ACC_W        = 97;   // signed accumulator of the magnitude sum
  localparam int RAD_W        = 96;   // radicand handed to the root unit
  localparam int ROOT_W       = RAD_W / 2;
  localparam int AMP_W        = 40;
  localparam int PH_W         = 16;
  localparam int CD_W         = 44;   // cordic vector width
  localparam int CZ_W         = 18;   // cordic angle width
  localparam int CORDIC_STEPS = 14;
  localparam int PI_Q13       = 25736;

  localparam logic signed [COEF_W-1:0] COEFF_RESET = 16'sd26510;
  localparam logic [BLEN_W-1:0]        BLEN_RESET  = 10'd100;

  typedef logic cfg_idx_t;
  localparam cfg_idx_t REG_COS_COEFF    = 1'b0;
  localparam cfg_idx_t REG_BLOCK_LENGTH = 1'b1;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_FB   = 9'b000000010,
    ST_UPD  = 9'b000000100,
    ST_CS   = 9'b000001000,
    ST_SQ1  = 9'b000010000,
    ST_SQ2  = 9'b000100000,
    ST_CR   = 9'b001000000,
    ST_ROOT = 9'b010000000,
    ST_OUT  = 9'b100000000
  } state_t;

  // arctangent of 2^-i in Q3.13
  function automatic logic [12:0] atan_q13(input logic [3:0] i);
    logic [12:0] r;
    case (i)
      4'd0:    r = 13'd6434;
      4'd1:    r = 13'd3798;
      4'd2:    r = 13'd2007;
      4'd3:    r = 13'd1019;
      4'd4:    r = 13'd511;
      4'd5:    r = 13'd256;
      4'd6:    r = 13'd128;
      4'd7:    r = 13'd64;
      4'd8:    r = 13'd32;
      4'd9:    r = 13'd16;
      4'd10:   r = 13'd8;
      4'd11:   r = 13'd4;
      4'd12:   r = 13'd2;
      4'd13:   r = 13'd1;
      default: r = 13'd0;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/gtd_in_if.sv @@
// gtd_in_if: sample channel, valid/ready with one sample per word
// depends on gtd_pkg
`timescale 1ns / 1ps

interface gtd_in_if;
  logic                          valid;
  logic                          ready;
  logic [gtd_pkg::SMP_W-1:0]     sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

@@ hdl/gtd_out_if.sv @@
// gtd_out_if: result channel, valid/ready carrying amplitude, phase and block end
// depends on gtd_pkg
`timescale 1ns / 1ps

interface gtd_out_if;
  logic                              valid;
  logic                              ready;
  logic [gtd_pkg::AMP_W-1:0]         amplitude;
  logic signed [gtd_pkg::PH_W-1:0]   phase;
  logic                              block_end;

  modport source (output valid, output amplitude, output phase, output block_end,
                  input ready);
  modport sink   (input valid, input amplitude, input phase, input block_end,
                  output ready);
endinterface

@@ hdl/gtd_mac.sv @@
// gtd_mac: bit-serial signed multiply-accumulate, one multiplier bit per cycle
// depends on gtd_pkg
`timescale 1ns / 1ps

module gtd_mac (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic                              clr,
  input  logic signed [gtd_pkg::MA_W-1:0]   a,
  input  logic signed [gtd_pkg::ST_W-1:0]   b,
  output logic signed [gtd_pkg::ACC_W-1:0]  acc,
  output logic                              done
);
  import gtd_pkg::*;

  localparam int CNT_W = $clog2(ST_W);

  logic signed [ACC_W-1:0] mcand;
  logic [ST_W-1:0]         mplier;
  logic [CNT_W-1:0]        cnt;
  logic                    busy;
  logic                    last;

  assign last = (cnt == CNT_W'(ST_W - 1));

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: top multiplier bit carries negative weight
  always_ff @(posedge clk) begin
    if (start) begin
      mcand  <= ACC_W'(a);
      mplier <= b;
      if (clr) begin
        acc <= '0;
      end
    end else if (busy) begin
      mcand  <= mcand <<< 1;
      mplier <= mplier >> 1;
      if (mplier[0]) begin
        acc <= last ? acc - mcand : acc + mcand;
      end
    end
  end

endmodule

@@ hdl/gtd_sqrt.sv @@
// gtd_sqrt: digit-by-digit integer square root, two radicand bits per cycle
// depends on gtd_pkg
`timescale 1ns / 1ps

module gtd_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [gtd_pkg::RAD_W-1:0]     rad,
  output logic [gtd_pkg::ROOT_W-1:0]    root,
  output logic                          done
);
  import gtd_pkg::*;

  localparam int REM_W = ROOT_W + 3;
  localparam int CNT_W = $clog2(ROOT_W);

  logic [RAD_W-1:0] rsh;
  logic [REM_W-1:0] rem;
  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             last;

  assign last   = (cnt == CNT_W'(ROOT_W - 1));
  assign rem_sh = {rem[REM_W-3:0], rsh[RAD_W-1 -: 2]};
  assign trial  = {1'b0, root, 2'b01};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // one root bit per step
  always_ff @(posedge clk) begin
    if (start) begin
      rsh  <= rad;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rsh <= rsh << 2;
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[ROOT_W-2:0], 1'b0};
      end
    end
  end

endmodule

@@ hdl/goertzel_tone_detector_top.sv @@
// goertzel_tone_detector_top: single-bin goertzel resonator with amplitude and phase
// depends on gtd_pkg, gtd_in_if, gtd_out_if, gtd_mac, gtd_sqrt
`timescale 1ns / 1ps

// Usage
//   in_s carries one 16-bit sample per word; out_s returns one word per sample
//   with amplitude, phase (Q3.13 radians) and block_end. Both use valid/ready.
//   cfg_we/cfg_index/cfg_data write cos_coeff (index 0) and block_length (1);
//   write only while no sample is in flight.
// Sequence
//   one sample at a time: after the accept edge, five serial multiplies of 40
//   bit steps each for the feedback and the squared magnitude, one update
//   step after the first, then the root with the 14-step arctangent alongside,
//   then the load of the output register. The next sample is taken only
//   after that load.
// Reset
//   rst clears states, count and handshakes and reloads cos_coeff = 26510,
//   block_length = 100.
// Stall
//   a result waits in the output register; the following sample is still
//   processed and holds in its last state until the register frees.

module goertzel_tone_detector_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  gtd_pkg::cfg_idx_t             cfg_index,
  input  logic [gtd_pkg::CFG_W-1:0]     cfg_data,
  gtd_in_if.sink                        in_s,
  gtd_out_if.source                     out_s
);
  import gtd_pkg::*;

  localparam int FW = 58;
  localparam logic signed [FW-1:0] ST_MAX_W = FW'((64'sd1 <<< (ST_W - 1)) - 64'sd1);
  localparam logic signed [FW-1:0] ST_MIN_W = -FW'(64'sd1 <<< (ST_W - 1));
  localparam logic signed [FW-1:0] RND_W    = FW'(64'sd8192);
  localparam logic signed [CZ_W-1:0] PI_Z   = CZ_W'(PI_Q13);

  state_t state, state_next, state_prev;

  logic signed [COEF_W-1:0] cos_coeff;
  logic [BLEN_W-1:0]        block_length;
  logic [SMP_W-1:0]         sample_q;
  logic signed [ST_W-1:0]   s1, s2;
  logic [BLEN_W-1:0]        count;
  logic [BLEN_W-1:0]        count_inc;
  logic                     bend;
  logic signed [MA_W-1:0]   negcs;
  logic                     amp_neg;

  logic                     mac_start, mac_clr, mac_done;
  logic signed [MA_W-1:0]   mac_a;
  logic signed [ST_W-1:0]   mac_b;
  logic signed [ACC_W-1:0]  mac_acc;

  logic                     fin_start, sq_done;
  logic [ROOT_W-1:0]        root;

  logic signed [FW-1:0]     prod_w, fb_w, snum;
  logic signed [ST_W-1:0]   snew;

  logic signed [CD_W-1:0]   cx, cy, dx, dy;
  logic signed [CZ_W-1:0]   cz, cz_step;
  logic [3:0]               ci;
  logic                     cbusy, czero;
  logic signed [PH_W-1:0]   phase_res;
  logic [AMP_W-1:0]         amp_res;
  logic                     out_free;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cos_coeff    <= COEFF_RESET;
      block_length <= BLEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COS_COEFF:    cos_coeff    <= $signed(cfg_data[COEF_W-1:0]);
        REG_BLOCK_LENGTH: block_length <= cfg_data[BLEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_s.ready = (state == ST_IDLE);
  assign out_free   = !out_s.valid || out_s.ready;
  assign count_inc  = count + 1'b1;

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_s.valid) state_next = ST_FB;
      ST_FB:   if (mac_done) state_next = ST_UPD;
      ST_UPD:  state_next = ST_CS;
      ST_CS:   if (mac_done) state_next = ST_SQ1;
      ST_SQ1:  if (mac_done) state_next = ST_SQ2;
      ST_SQ2:  if (mac_done) state_next = ST_CR;
      ST_CR:   if (mac_done) state_next = ST_ROOT;
      ST_ROOT: if (sq_done) state_next = ST_OUT;
      ST_OUT:  if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      state_prev <= ST_IDLE;
    end else begin
      state      <= state_next;
      state_prev <= state;
    end
  end

  // multiplier operands per step
  always_comb begin
    mac_a = MA_W'(cos_coeff);
    mac_b = s1;
    case (state)
      ST_SQ1: begin
        mac_a = MA_W'($signed({s1, 14'b0}));
        mac_b = s1;
      end
      ST_SQ2: begin
        mac_a = MA_W'($signed({s2, 14'b0}));
        mac_b = s2;
      end
      ST_CR: begin
        mac_a = negcs;
        mac_b = s2;
      end
      default: ;
    endcase
  end

  assign mac_start = (state != state_prev) &&
                     (state == ST_FB || state == ST_CS || state == ST_SQ1 ||
                      state == ST_SQ2 || state == ST_CR);
  assign mac_clr   = (state == ST_FB || state == ST_CS || state == ST_SQ1);
  assign fin_start = (state == ST_ROOT) && (state_prev != ST_ROOT);

  gtd_mac u_mac (
    .clk   (clk),
    .rst   (rst),
    .start (mac_start),
    .clr   (mac_clr),
    .a     (mac_a),
    .b     (mac_b),
    .acc   (mac_acc),
    .done  (mac_done)
  );

  gtd_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (fin_start),
    .rad   (mac_acc[RAD_W-1:0]),
    .root  (root),
    .done  (sq_done)
  );

  // resonator update with rounding and saturation
  always_comb begin
    prod_w = FW'($signed(mac_acc[MA_W-1:0]));
    fb_w   = (prod_w + RND_W) >>> 14;
    snum   = fb_w + FW'($signed({1'b0, sample_q[SAMPLE_WIDTH-1:0]})) - FW'(s2);
    if (snum > ST_MAX_W) begin
      snew = ST_W'(ST_MAX_W);
    end else if (snum < ST_MIN_W) begin
      snew = ST_W'(ST_MIN_W);
    end else begin
      snew = ST_W'(snum);
    end
  end

  // state, count and captured operands
  always_ff @(posedge clk) begin
    if (rst) begin
      s1    <= '0;
      s2    <= '0;
      count <= '0;
      bend  <= 1'b0;
    end else begin
      if (state == ST_UPD) begin
        s2    <= s1;
        s1    <= snew;
        count <= count_inc;
        bend  <= (count_inc == block_length);
      end
      if (state == ST_ROOT && sq_done && bend) begin
        s1    <= '0;
        s2    <= '0;
        count <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_s.valid && in_s.ready) begin
      sample_q <= in_s.sample;
    end
    if (state == ST_CS && mac_done) begin
      negcs <= -$signed(mac_acc[MA_W-1:0]);
    end
    if (state == ST_CR && mac_done) begin
      amp_neg <= mac_acc[ACC_W-1];
    end
  end

  // cordic vectoring, one micro-rotation per cycle
  assign dx      = cy >>> ci;
  assign dy      = cx >>> ci;
  assign cz_step = CZ_W'(atan_q13(ci));

  always_ff @(posedge clk) begin
    if (rst) begin
      cbusy <= 1'b0;
      ci    <= '0;
    end else if (fin_start) begin
      cbusy <= 1'b1;
      ci    <= '0;
    end else if (cbusy) begin
      ci <= ci + 1'b1;
      if (ci == 4'(CORDIC_STEPS - 1)) begin
        cbusy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin_start) begin
      czero <= (s1 == '0) && (s2 == '0);
      if (s2 < 0) begin
        cx <= -CD_W'(s2);
        cy <= -CD_W'(s1);
        cz <= (s1 >= 0) ? PI_Z : -PI_Z;
      end else begin
        cx <= CD_W'(s2);
        cy <= CD_W'(s1);
        cz <= '0;
      end
    end else if (cbusy) begin
      if (cy < 0) begin
        cx <= cx - dx;
        cy <= cy + dy;
        cz <= cz - cz_step;
      end else begin
        cx <= cx + dx;
        cy <= cy - dy;
        cz <= cz + cz_step;
      end
    end
  end

  // result formatting
  always_comb begin
    if (czero) begin
      phase_res = '0;
    end else if (cz > PI_Z) begin
      phase_res = PH_W'(PI_Z);
    end else if (cz < -PI_Z) begin
      phase_res = PH_W'(-PI_Z);
    end else begin
      phase_res = PH_W'(cz);
    end
    if (amp_neg) begin
      amp_res = '0;
    end else if (root[ROOT_W-1 -: (ROOT_W - 7 - AMP_W)] != '0) begin
      amp_res = '1;
    end else begin
      amp_res = root[AMP_W+6:7];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_s.valid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      out_s.valid <= 1'b1;
    end else if (out_s.ready) begin
      out_s.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      out_s.amplitude <= amp_res;
      out_s.phase     <= phase_res;
      out_s.block_end <= bend;
    end
  end

  // checks
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_s.valid && in_s.ready |=> state == ST_FB)
    else $error("accepted word did not start the feedback multiply");

  a_load_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(out_s.valid) |-> $past(state == ST_OUT))
    else $error("result loaded outside the output step");

  a_block_cleared: assert property (@(posedge clk) disable iff (rst)
    state == ST_OUT && bend |-> s1 == '0 && s2 == '0 && count == '0)
    else $error("states not cleared at block end");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    out_s.valid |-> out_s.phase <= PH_W'(PI_Z) && out_s.phase >= PH_W'(-PI_Z))
    else $error("phase out of range");

  a_cordic_done: assert property (@(posedge clk) disable iff (rst)
    sq_done |-> !cbusy)
    else $error("arctangent still running when root finished");

endmodule
